[hw/rtl/particle_euler_update_macros.svh]
// ---------------------------------------------------------------------------
// particle_euler_update assertion macros
// Clocked assertion wrappers used by the checker file.
// ---------------------------------------------------------------------------
`ifndef PARTICLE_EULER_UPDATE_MACROS_SVH
`define PARTICLE_EULER_UPDATE_MACROS_SVH

// checked only outside reset
`define PEU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define PEU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/peu_pkg.sv]
// ---------------------------------------------------------------------------
// peu_pkg
// Types, constants and helper functions of the particle Euler update block.
// ---------------------------------------------------------------------------
package peu_pkg;

  typedef logic signed [31:0] q16_t;

  localparam int StepW    = 24;
  localparam int GravW    = 20;
  localparam int FactW    = 21;
  localparam int QOne     = 65536;
  localparam int KGravity = 3277;
  localparam int KDrift   = 1311;
  localparam int KShrink  = 328;

  localparam logic [StepW-1:0] StepTimeReset = StepW'(QOne);
  localparam q16_t             KMinSize      = 32'sd19661;
  localparam q16_t             Q16Max        = 32'sh7fff_ffff;
  localparam q16_t             Q16Min        = 32'sh8000_0000;

  localparam int MidDepthDefault = 2;
  localparam int OutDepthDefault = 4;

  typedef struct packed {
    q16_t       pos_x;
    q16_t       pos_y;
    q16_t       vel_x;
    q16_t       vel_y;
    q16_t       life;
    q16_t       decay_rate;
    q16_t       size;
    logic [2:0] mode_bits;
    logic       last;
  } particle_t;

  typedef struct packed {
    logic active;
    logic gravity;
    logic drift;
  } class_t;

  typedef struct packed {
    particle_t rec;
    class_t    cls;
  } mid_entry_t;

  typedef struct packed {
    logic [StepW-1:0]        dt;
    logic [GravW-1:0]        grav_inc;
    logic signed [FactW-1:0] drift_f;
    logic signed [FactW-1:0] shrink_f;
  } step_cfg_t;

  // per-step terms that depend only on dt
  function automatic step_cfg_t derive_step(input logic [StepW-1:0] dt);
    logic [39:0] g;
    logic [39:0] d;
    logic [39:0] s;
    step_cfg_t   c;
    g          = 40'(dt) * 40'(KGravity);
    d          = 40'(dt) * 40'(KDrift);
    s          = 40'(dt) * 40'(KShrink);
    c.dt       = dt;
    c.grav_inc = g[16 +: GravW];
    c.drift_f  = $signed(FactW'(QOne)) - $signed(d[16 +: FactW]);
    c.shrink_f = $signed(FactW'(QOne)) - $signed(s[16 +: FactW]);
    return c;
  endfunction

  function automatic q16_t sat32(input logic signed [63:0] v);
    q16_t r;
    if (v > 64'(Q16Max)) begin
      r = Q16Max;
    end else if (v < 64'(Q16Min)) begin
      r = Q16Min;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/peu_front.sv]
// ---------------------------------------------------------------------------
// peu_front
// Accepts particle records, tags them by update class and queues them.
// ---------------------------------------------------------------------------
module peu_front #(
  parameter int MID_DEPTH = peu_pkg::MidDepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  peu_pkg::particle_t  in_rec,
  output logic                mid_valid,
  output peu_pkg::mid_entry_t mid_entry,
  input  logic                mid_pop
);
  import peu_pkg::*;

  localparam int AW = $clog2(MID_DEPTH);
  localparam int CW = $clog2(MID_DEPTH + 1);

  mid_entry_t      mem [MID_DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;
  mid_entry_t      new_entry;

  always_comb begin
    new_entry.rec         = in_rec;
    new_entry.cls.active  = in_rec.mode_bits[0];
    new_entry.cls.gravity = in_rec.mode_bits[0] & in_rec.mode_bits[1];
    new_entry.cls.drift   = in_rec.mode_bits[0] & in_rec.mode_bits[2];
  end

  assign full      = (count == CW'(MID_DEPTH));
  assign mid_valid = (count != '0);
  assign do_push   = push & ~full;
  assign do_pop    = mid_pop & mid_valid;
  assign mid_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(MID_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(MID_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/peu_back.sv]
// ---------------------------------------------------------------------------
// peu_back
// Multiply stage, saturating update and result queue for particle records.
// ---------------------------------------------------------------------------
module peu_back #(
  parameter int OUT_DEPTH = peu_pkg::OutDepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  peu_pkg::step_cfg_t  cfg,
  input  logic                mid_valid,
  input  peu_pkg::mid_entry_t mid_entry,
  output logic                mid_pop,
  output logic                empty,
  input  logic                pop,
  output peu_pkg::particle_t  out_rec
);
  import peu_pkg::*;

  localparam int AW  = $clog2(OUT_DEPTH);
  localparam int CW  = $clog2(OUT_DEPTH + 1);
  localparam int PDW = 32 + StepW + 1;
  localparam int PFW = 32 + FactW;

  logic                  s1_valid;
  particle_t             s1_rec;
  class_t                s1_cls;
  logic signed [PDW-1:0] prod_px;
  logic signed [PDW-1:0] prod_py;
  logic signed [PDW-1:0] prod_life;
  logic signed [PFW-1:0] prod_vx;
  logic signed [PFW-1:0] prod_size;
  logic signed [StepW:0] dt_s;

  particle_t             res;
  q16_t                  life_w;
  q16_t                  size_w;

  particle_t             mem [OUT_DEPTH];
  logic [AW-1:0]         wr_ptr;
  logic [AW-1:0]         rd_ptr;
  logic [CW-1:0]         count;
  logic                  do_pop;

  assign dt_s = $signed({1'b0, cfg.dt});

  // only take a request when the result queue can hold everything in flight
  assign mid_pop = mid_valid &&
                   (({1'b0, count} + (CW+1)'(s1_valid)) < (CW+1)'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= mid_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      s1_rec    <= mid_entry.rec;
      s1_cls    <= mid_entry.cls;
      prod_px   <= mid_entry.rec.vel_x * dt_s;
      prod_py   <= mid_entry.rec.vel_y * dt_s;
      prod_life <= mid_entry.rec.decay_rate * dt_s;
      prod_vx   <= mid_entry.rec.vel_x * cfg.drift_f;
      prod_size <= mid_entry.rec.size * cfg.shrink_f;
    end
  end

  always_comb begin
    res    = s1_rec;
    life_w = sat32(64'(s1_rec.life) - 64'(prod_life >>> 16));
    size_w = sat32(64'(prod_size >>> 16));
    if (size_w < KMinSize) begin
      size_w = KMinSize;
    end
    if (s1_cls.active) begin
      res.pos_x = sat32(64'(s1_rec.pos_x) + 64'(prod_px >>> 16));
      res.pos_y = sat32(64'(s1_rec.pos_y) + 64'(prod_py >>> 16));
      if (s1_cls.gravity) begin
        res.vel_y = sat32(64'(s1_rec.vel_y) + 64'({1'b0, cfg.grav_inc}));
      end
      if (s1_cls.drift) begin
        res.vel_x = sat32(64'(prod_vx >>> 16));
      end
      res.size = size_w;
      res.life = life_w;
      // life ran out: clamp and deactivate
      if (life_w <= 0) begin
        res.life         = '0;
        res.mode_bits[0] = 1'b0;
      end
    end
  end

  assign empty   = (count == '0);
  assign do_pop  = pop & ~empty;
  assign out_rec = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      mem[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (s1_valid) begin
        wr_ptr <= (wr_ptr == AW'(OUT_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(OUT_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (s1_valid && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !s1_valid) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/particle_euler_update.sv]
// ---------------------------------------------------------------------------
// particle_euler_update
// One Euler time step per particle record, signed Q16.16, saturating.
// ---------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: a request is taken at a clock edge with
//   push high and full low. Result side is a queue read port: the oldest
//   result sits on the new_* ports while empty is low and leaves at an edge
//   with pop high and empty low. Every request yields exactly one result, in
//   order.
//   step_time (dt) is written with step_time_we; write it only while no
//   request is in flight. Terms derived from dt are computed at the write.
//   A request passes from the input queue through the multiply stage into
//   the result queue. Throughput: one request per cycle while the result
//   queue has room, set by the single multiply stage feeding it.
//   Reset (rst, synchronous): both queues empty, dt = 1.0.
//   Receiver stall: the result queue (OUT_DEPTH deep) fills first, then the
//   input queue (MID_DEPTH deep), after which full rises; nothing is dropped.
// ---------------------------------------------------------------------------
module particle_euler_update #(
  parameter int MID_DEPTH = peu_pkg::MidDepthDefault,
  parameter int OUT_DEPTH = peu_pkg::OutDepthDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step_time_we,
  input  logic [peu_pkg::StepW-1:0]   step_time,
  input  logic                        push,
  output logic                        full,
  input  peu_pkg::q16_t               pos_x,
  input  peu_pkg::q16_t               pos_y,
  input  peu_pkg::q16_t               vel_x,
  input  peu_pkg::q16_t               vel_y,
  input  peu_pkg::q16_t               life,
  input  peu_pkg::q16_t               decay_rate,
  input  peu_pkg::q16_t               size,
  input  logic [2:0]                  mode_bits,
  input  logic                        last_in,
  output logic                        empty,
  input  logic                        pop,
  output peu_pkg::q16_t               new_pos_x,
  output peu_pkg::q16_t               new_pos_y,
  output peu_pkg::q16_t               new_vel_x,
  output peu_pkg::q16_t               new_vel_y,
  output peu_pkg::q16_t               new_life,
  output peu_pkg::q16_t               out_decay,
  output peu_pkg::q16_t               new_size,
  output logic [2:0]                  new_mode_bits,
  output logic                        last_out
);
  import peu_pkg::*;

  step_cfg_t  cfg;
  particle_t  in_rec;
  particle_t  out_rec;
  logic       mid_valid;
  mid_entry_t mid_entry;
  logic       mid_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= derive_step(StepTimeReset);
    end else if (step_time_we) begin
      cfg <= derive_step(step_time);
    end
  end

  always_comb begin
    in_rec.pos_x      = pos_x;
    in_rec.pos_y      = pos_y;
    in_rec.vel_x      = vel_x;
    in_rec.vel_y      = vel_y;
    in_rec.life       = life;
    in_rec.decay_rate = decay_rate;
    in_rec.size       = size;
    in_rec.mode_bits  = mode_bits;
    in_rec.last       = last_in;
  end

  peu_front #(
    .MID_DEPTH(MID_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_rec   (in_rec),
    .mid_valid(mid_valid),
    .mid_entry(mid_entry),
    .mid_pop  (mid_pop)
  );

  peu_back #(
    .OUT_DEPTH(OUT_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .mid_valid(mid_valid),
    .mid_entry(mid_entry),
    .mid_pop  (mid_pop),
    .empty    (empty),
    .pop      (pop),
    .out_rec  (out_rec)
  );

  assign new_pos_x     = out_rec.pos_x;
  assign new_pos_y     = out_rec.pos_y;
  assign new_vel_x     = out_rec.vel_x;
  assign new_vel_y     = out_rec.vel_y;
  assign new_life      = out_rec.life;
  assign out_decay     = out_rec.decay_rate;
  assign new_size      = out_rec.size;
  assign new_mode_bits = out_rec.mode_bits;
  assign last_out      = out_rec.last;

endmodule

[hw/rtl/peu_checker.sv]
// ---------------------------------------------------------------------------
// peu_checker
// Port-level checks of the particle Euler update block, bound to the top.
// ---------------------------------------------------------------------------
`include "particle_euler_update_macros.svh"

module peu_checker (
  input logic                clk,
  input logic                rst,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input peu_pkg::q16_t       new_pos_x,
  input peu_pkg::q16_t       new_life,
  input peu_pkg::q16_t       new_size,
  input logic [2:0]          new_mode_bits
);
  import peu_pkg::*;

  // reset leaves both queues empty
  `PEU_ASSERT_ALWAYS(a_rst_empty, rst |=> (empty && !full), "queues not empty after reset")

  // a result still marked active must have life left
  `PEU_ASSERT(a_active_life, (!empty && new_mode_bits[0]) |-> (!new_life[31] && new_life != 0), "active result with no life")

  // active results never drop below the size floor
  `PEU_ASSERT(a_size_floor, (!empty && new_mode_bits[0]) |-> (new_size >= KMinSize), "active result below size floor")

  `PEU_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(new_pos_x) && $stable(new_size)), "stalled result changed")

endmodule

bind particle_euler_update peu_checker u_peu_checker (
  .clk          (clk),
  .rst          (rst),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .new_pos_x    (new_pos_x),
  .new_life     (new_life),
  .new_size     (new_size),
  .new_mode_bits(new_mode_bits)
);
